// ===== hw/rtl/osfc_pkg.sv =====
// ============================================================================
// osfc_pkg - shared types and constants for the observer/feedback controller
// Register codes, reset values, microcode word layout and the microprogram
// ROM that sequences the shared multiply-accumulate datapath.
// ============================================================================
package osfc_pkg;

    // Default widths (top-level parameters take these)
    localparam int COEF_WIDTH_DEF  = 16;
    localparam int STATE_WIDTH_DEF = 32;

    // Fixed field widths and scaling
    localparam int CODE_BITS   = 12;
    localparam int CODE_MAX    = (1 << CODE_BITS) - 1;
    localparam int EST_FRAC    = 12;
    localparam int RND_EST     = 1 << (EST_FRAC - 1);
    localparam int EST_OUT_W   = 16;
    localparam int EST_OUT_MAX = (1 << (EST_OUT_W - 1)) - 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values (Q2.13 at default width)
    localparam int RST_A00 = 9948;
    localparam int RST_A01 = -2551;
    localparam int RST_C0  = 473;
    localparam int RST_C1  = 321;
    localparam int RST_K0  = 1176;
    localparam int RST_K1  = 7258;
    localparam int RST_KO  = 16883;
    localparam int RST_L0  = 9948;
    localparam int RST_L1  = -2551;

    // Sequencer
    localparam int PC_W    = 4;
    localparam int UC_LAST = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A00   = 3'd0,
        CFG_A01   = 3'd1,
        CFG_C0    = 3'd2,
        CFG_C1    = 3'd3,
        CFG_K0    = 3'd4,
        CFG_K1    = 3'd5,
        CFG_KO    = 3'd6,
        CFG_GAINS = 3'd7
    } cfg_idx_t;

    // Multiplier coefficient select
    typedef enum logic [3:0] {
        CS_KO, CS_K0, CS_K1, CS_C0, CS_C1, CS_A00, CS_A01, CS_L0, CS_L1
    } coef_sel_t;

    // Multiplier data operand select
    typedef enum logic [1:0] {
        XS_REF, XS_E0, XS_E1, XS_INNOV
    } opnd_sel_t;

    // Accumulator operation on the product registered last step
    typedef enum logic [2:0] {
        ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_Y_SUB, ACC_US_ADD, ACC_E0_ADD
    } acc_op_t;

    // Step sequencing: advance, or emit result and stop when output is free
    typedef enum logic {
        SEQ_NEXT, SEQ_EMIT
    } seq_op_t;

    typedef struct packed {
        coef_sel_t coef;
        opnd_sel_t opnd;
        acc_op_t   acc;
        logic      save_u;      // latch drive: DAC code, clip, saturated drive
        logic      save_innov;  // latch saturated innovation
        logic      save_n0;     // latch saturated new est0
        logic      write_est;   // commit new estimates
        seq_op_t   seq;
    } ucode_t;

    // Microprogram. Each word issues one multiply and applies the
    // accumulator op to the product issued by the previous word.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        begin
            unique case (pc)
                4'd0:  w = '{CS_KO,  XS_REF,   ACC_NOP,    1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT};
                4'd1:  w = '{CS_K0,  XS_E0,    ACC_LOAD,   1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT};
                4'd2:  w = '{CS_K1,  XS_E1,    ACC_SUB,    1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT};
                4'd3:  w = '{CS_C0,  XS_E0,    ACC_SUB,    1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT};
                4'd4:  w = '{CS_C1,  XS_E1,    ACC_Y_SUB,  1'b1, 1'b0, 1'b0, 1'b0, SEQ_NEXT};
                4'd5:  w = '{CS_A00, XS_E0,    ACC_SUB,    1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT};
                4'd6:  w = '{CS_A01, XS_E1,    ACC_US_ADD, 1'b0, 1'b1, 1'b0, 1'b0, SEQ_NEXT};
                4'd7:  w = '{CS_L0,  XS_INNOV, ACC_ADD,    1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT};
                4'd8:  w = '{CS_L1,  XS_INNOV, ACC_ADD,    1'b0, 1'b0, 1'b0, 1'b0, SEQ_NEXT};
                4'd9:  w = '{CS_KO,  XS_REF,   ACC_E0_ADD, 1'b0, 1'b0, 1'b1, 1'b0, SEQ_NEXT};
                4'd10: w = '{CS_KO,  XS_REF,   ACC_NOP,    1'b0, 1'b0, 1'b0, 1'b1, SEQ_NEXT};
                4'd11: w = '{CS_KO,  XS_REF,   ACC_NOP,    1'b0, 1'b0, 1'b0, 1'b0, SEQ_EMIT};
                default: w = '{CS_KO, XS_REF,  ACC_NOP,    1'b0, 1'b0, 1'b0, 1'b0, SEQ_EMIT};
            endcase
            return w;
        end
    endfunction

endpackage

// ===== hw/rtl/observer_state_feedback_controller_core.sv =====
// ============================================================================
// observer_state_feedback_controller_core - 2nd-order observer with feedback
// Computes a saturated DAC drive from a reference and the held estimate, then
// advances a fixed-point observer, on one shared microcoded multiplier.
// ============================================================================
// Usage:
//   Slave stream carries one sample per item: measured output y_code and
//   reference ref_code. Master stream returns one result item per sample:
//   DAC code, the updated estimates, and a clip flag in tuser.
//   Coefficients are written through cfg_we/cfg_index/cfg_data while the
//   block is idle; each write takes effect at the next clock edge.
//   Each item runs through the twelve-word microprogram on the single
//   coefficient-by-state multiplier; a new item is taken only once the
//   sequencer has finished the last one and gone idle.
//   The input is taken whenever the sequencer is idle, even while an earlier
//   result still waits in the output register. If the receiver stalls, the
//   sequencer holds on its final step until the output register frees up.
//   Reset clears both estimates, loads the coefficient reset values and
//   empties the output register.
// ============================================================================
module observer_state_feedback_controller_core #(
    parameter int COEF_WIDTH  = osfc_pkg::COEF_WIDTH_DEF,
    parameter int STATE_WIDTH = osfc_pkg::STATE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [osfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [osfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // sample input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,   // y_code[11:0], ref_code[23:12]
    // result output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [47:0]                      m_axis_tdata,   // dac_code[11:0], est0_out[27:12],
                                                             // est1_out[43:28], zero fill
    output logic                             m_axis_tuser    // clipped
);
    import osfc_pkg::*;

    localparam int CF      = COEF_WIDTH - 3;           // coefficient fraction bits
    localparam int XW      = STATE_WIDTH + 1;          // multiplier data operand
    localparam int PROD_W  = COEF_WIDTH + XW;
    localparam int PW      = PROD_W - CF;              // rounded product
    localparam int ACC_W   = STATE_WIDTH + 7;
    localparam int GAINS_W = 2 * COEF_WIDTH;
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (CF - 1);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic signed [STATE_WIDTH-1:0] sat_state(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        begin
            hi = ACC_W'({1'b0, {(STATE_WIDTH-1){1'b1}}});
            lo = -hi - ACC_W'(1);
            if (v > hi)
                return hi[STATE_WIDTH-1:0];
            else if (v < lo)
                return lo[STATE_WIDTH-1:0];
            else
                return v[STATE_WIDTH-1:0];
        end
    endfunction

    // round to integer code, ties up
    function automatic logic signed [ACC_W-1:0] round_int(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] t;
        begin
            t = v + ACC_W'(RND_EST);
            return t >>> EST_FRAC;
        end
    endfunction

    function automatic logic [EST_OUT_W-1:0] est_code(
        input logic signed [STATE_WIDTH-1:0] e
    );
        logic signed [ACC_W-1:0] q;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        begin
            q  = round_int(ACC_W'(e));
            hi = ACC_W'(EST_OUT_MAX);
            lo = -hi - ACC_W'(1);
            if (q > hi)
                return hi[EST_OUT_W-1:0];
            else if (q < lo)
                return lo[EST_OUT_W-1:0];
            else
                return q[EST_OUT_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic signed [COEF_WIDTH-1:0]  a00_reg, a01_reg, c0_reg, c1_reg;
    logic signed [COEF_WIDTH-1:0]  k0_reg, k1_reg, ko_reg, l0_reg, l1_reg;
    logic signed [STATE_WIDTH-1:0] est0_reg, est0_next;
    logic signed [STATE_WIDTH-1:0] est1_reg, est1_next;
    logic                          busy_reg, busy_next;
    logic [PC_W-1:0]               pc_reg, pc_next;
    logic                          out_valid_reg, out_valid_next;

    logic [CODE_BITS-1:0]          y_reg, ref_reg;
    logic signed [PW-1:0]          p_reg, p_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic signed [STATE_WIDTH-1:0] us_reg, innov_reg, n0_reg;
    logic [CODE_BITS-1:0]          dac_tmp_reg;
    logic                          clip_tmp_reg;
    logic [CODE_BITS-1:0]          dac_out_reg;
    logic                          clip_out_reg;
    logic [EST_OUT_W-1:0]          est0_out_reg, est1_out_reg;

    logic [GAINS_W-1:0]            gains_ext;
    ucode_t                        uc;
    logic                          accept;
    logic                          emit;
    logic signed [COEF_WIDTH-1:0]  coef_x;
    logic signed [XW-1:0]          opnd_x;
    logic signed [PROD_W-1:0]      prod_full, prod_rnd;
    logic signed [ACC_W-1:0]       p_ext, yq, code_u;
    logic [CODE_BITS-1:0]          dac_u;
    logic                          clip_u;

    assign gains_ext = GAINS_W'(cfg_data);
    assign uc        = ucode_rom(pc_reg);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign emit      = busy_reg && (uc.seq == SEQ_EMIT) && (!out_valid_reg || m_axis_tready);

    // ------------------------------------------------------------------
    // Multiplier stage: coefficient x operand, rounded to state LSB
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (uc.coef)
            CS_KO:   coef_x = ko_reg;
            CS_K0:   coef_x = k0_reg;
            CS_K1:   coef_x = k1_reg;
            CS_C0:   coef_x = c0_reg;
            CS_C1:   coef_x = c1_reg;
            CS_A00:  coef_x = a00_reg;
            CS_A01:  coef_x = a01_reg;
            CS_L0:   coef_x = l0_reg;
            CS_L1:   coef_x = l1_reg;
            default: coef_x = ko_reg;
        endcase
        unique case (uc.opnd)
            XS_REF:   opnd_x = signed'(XW'({ref_reg, {EST_FRAC{1'b0}}}));
            XS_E0:    opnd_x = XW'(est0_reg);
            XS_E1:    opnd_x = XW'(est1_reg);
            XS_INNOV: opnd_x = XW'(innov_reg);
            default:  opnd_x = XW'(est0_reg);
        endcase
        prod_full = PROD_W'(coef_x) * PROD_W'(opnd_x);
        prod_rnd  = prod_full + RND_HALF;
        p_next    = prod_rnd[PROD_W-1:CF];
    end

    // ------------------------------------------------------------------
    // Accumulator stage
    // ------------------------------------------------------------------
    assign p_ext = ACC_W'(p_reg);
    assign yq    = signed'(ACC_W'({y_reg, {EST_FRAC{1'b0}}}));

    always_comb
    begin
        unique case (uc.acc)
            ACC_NOP:    acc_next = acc_reg;
            ACC_LOAD:   acc_next = p_ext;
            ACC_ADD:    acc_next = acc_reg + p_ext;
            ACC_SUB:    acc_next = acc_reg - p_ext;
            ACC_Y_SUB:  acc_next = yq - p_ext;
            ACC_US_ADD: acc_next = ACC_W'(us_reg) + p_ext;
            ACC_E0_ADD: acc_next = ACC_W'(est0_reg) + p_ext;
            default:    acc_next = acc_reg;
        endcase
    end

    // Drive to DAC code with clip detect
    always_comb
    begin
        code_u = round_int(acc_reg);
        clip_u = code_u[ACC_W-1] || (code_u > ACC_W'(CODE_MAX));
        if (code_u[ACC_W-1])
            dac_u = '0;
        else if (code_u > ACC_W'(CODE_MAX))
            dac_u = CODE_BITS'(CODE_MAX);
        else
            dac_u = code_u[CODE_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Sequencer and state next values
    // ------------------------------------------------------------------
    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        est0_next      = est0_reg;
        est1_next      = est1_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (busy_reg)
        begin
            if (uc.seq == SEQ_NEXT)
                pc_next = pc_reg + PC_W'(1);
            if (emit)
            begin
                busy_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            if (uc.write_est)
            begin
                est0_next = n0_reg;
                est1_next = sat_state(acc_reg);
            end
        end
    end

    // Control state, estimates and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            est0_reg      <= '0;
            est1_reg      <= '0;
            a00_reg       <= COEF_WIDTH'(RST_A00);
            a01_reg       <= COEF_WIDTH'(RST_A01);
            c0_reg        <= COEF_WIDTH'(RST_C0);
            c1_reg        <= COEF_WIDTH'(RST_C1);
            k0_reg        <= COEF_WIDTH'(RST_K0);
            k1_reg        <= COEF_WIDTH'(RST_K1);
            ko_reg        <= COEF_WIDTH'(RST_KO);
            l0_reg        <= COEF_WIDTH'(RST_L0);
            l1_reg        <= COEF_WIDTH'(RST_L1);
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            est0_reg      <= est0_next;
            est1_reg      <= est1_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_A00:   a00_reg <= cfg_data[COEF_WIDTH-1:0];
                    CFG_A01:   a01_reg <= cfg_data[COEF_WIDTH-1:0];
                    CFG_C0:    c0_reg  <= cfg_data[COEF_WIDTH-1:0];
                    CFG_C1:    c1_reg  <= cfg_data[COEF_WIDTH-1:0];
                    CFG_K0:    k0_reg  <= cfg_data[COEF_WIDTH-1:0];
                    CFG_K1:    k1_reg  <= cfg_data[COEF_WIDTH-1:0];
                    CFG_KO:    ko_reg  <= cfg_data[COEF_WIDTH-1:0];
                    CFG_GAINS:
                    begin
                        l0_reg <= gains_ext[COEF_WIDTH-1:0];
                        l1_reg <= gains_ext[GAINS_W-1:COEF_WIDTH];
                    end
                    default: ;
                endcase
            end
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            y_reg   <= s_axis_tdata[11:0];
            ref_reg <= s_axis_tdata[23:12];
        end
        if (busy_reg)
        begin
            p_reg   <= p_next;
            acc_reg <= acc_next;
            if (uc.save_u)
            begin
                us_reg       <= sat_state(acc_reg);
                dac_tmp_reg  <= dac_u;
                clip_tmp_reg <= clip_u;
            end
            if (uc.save_innov)
                innov_reg <= sat_state(acc_reg);
            if (uc.save_n0)
                n0_reg <= sat_state(acc_reg);
        end
        if (emit)
        begin
            dac_out_reg  <= dac_tmp_reg;
            clip_out_reg <= clip_tmp_reg;
            est0_out_reg <= est_code(est0_reg);
            est1_out_reg <= est_code(est1_reg);
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_axis_tready = !busy_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, est1_out_reg, est0_out_reg, dac_out_reg};
    assign m_axis_tuser  = clip_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= PC_W'(UC_LAST)))
        else $error("step counter ran past the microprogram");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && (pc_reg == '0)))
        else $error("accepted item did not start the microprogram");

    a_emit_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(busy_reg && (pc_reg == PC_W'(UC_LAST))))
        else $error("result raised outside the final step");

    a_est_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && uc.write_est) |=> ($stable(est0_reg) && $stable(est1_reg)))
        else $error("estimate changed outside the commit step");

endmodule
